### hdl/cmdr_pkg.sv
package cmdr_pkg;

	localparam int REGION_X_DEF = 32;
	localparam int REGION_Y_DEF = 32;
	localparam int REGION_Z_DEF = 32;

	localparam logic [1:0] MODE_DEPOSIT = 2'd0;
	localparam logic [1:0] MODE_READOUT = 2'd1;
	localparam logic [1:0] MODE_CLEAR   = 2'd2;
	localparam logic [1:0] MODE_NONE    = 2'd3;

	localparam logic [3:0] CFG_MESH_X    = 4'd0;
	localparam logic [3:0] CFG_MESH_Y    = 4'd1;
	localparam logic [3:0] CFG_MESH_Z    = 4'd2;
	localparam logic [3:0] CFG_START_X   = 4'd3;
	localparam logic [3:0] CFG_START_Y   = 4'd4;
	localparam logic [3:0] CFG_INV_X     = 4'd5;
	localparam logic [3:0] CFG_INV_Y     = 4'd6;
	localparam logic [3:0] CFG_INV_Z     = 4'd7;

	typedef struct packed {
		logic [1:0]         mode;
		logic [31:0]        pos_x;
		logic [31:0]        pos_y;
		logic [31:0]        pos_z;
		logic signed [31:0] weight;
	} item_t;

	typedef struct packed {
		logic signed [47:0] value;
		logic [3:0]         cells_touched;
		logic               out_of_range;
		logic               saturated;
	} result_t;

	typedef enum logic [3:0] {
		S_INIT_CLR,
		S_IDLE,
		S_MUL,
		S_WRAP,
		S_REL,
		S_ADDR,
		S_FACT,
		S_PROD,
		S_ACC,
		S_CLR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mul;
		logic       wrap;
		logic       rel;
		logic       addr;
		logic       fact;
		logic       prod;
		logic       acc;
		logic       clr_wr;
		logic [2:0] corner;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       oor;
		logic       corner_in;
		logic       clr_last;
	} sts_t;

endpackage

### hdl/cmdr_ctrl.sv
module cmdr_ctrl
	import cmdr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  sts_t   sts,
	output cmd_t   cmd,
	output logic   busy,
	output logic   done
);

	state_t     state_q, state_nx;
	logic [2:0] corner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT_CLR;
			corner_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_IDLE)
				corner_q <= '0;
			else if ((state_q == S_ADDR && !sts.corner_in) || state_q == S_ACC)
				corner_q <= corner_q + 3'd1;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_INIT_CLR: if (sts.clr_last) state_nx = S_IDLE;
			S_IDLE:     if (start) state_nx = S_MUL;
			S_MUL: begin
				case (sts.mode)
					MODE_CLEAR: state_nx = S_CLR;
					MODE_NONE:  state_nx = S_DONE;
					default:    state_nx = S_WRAP;
				endcase
			end
			S_WRAP:     state_nx = S_REL;
			S_REL:      state_nx = sts.oor ? S_DONE : S_ADDR;
			S_ADDR: begin
				if (sts.corner_in)
					state_nx = S_FACT;
				else if (corner_q == 3'd7)
					state_nx = S_DONE;
			end
			S_FACT:     state_nx = S_PROD;
			S_PROD:     state_nx = S_ACC;
			S_ACC:      state_nx = (corner_q == 3'd7) ? S_DONE : S_ADDR;
			S_CLR:      if (sts.clr_last) state_nx = S_DONE;
			S_DONE:     state_nx = S_IDLE;
			default:    state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && start;
		cmd.mul    = (state_q == S_MUL);
		cmd.wrap   = (state_q == S_WRAP);
		cmd.rel    = (state_q == S_REL);
		cmd.addr   = (state_q == S_ADDR);
		cmd.fact   = (state_q == S_FACT);
		cmd.prod   = (state_q == S_PROD);
		cmd.acc    = (state_q == S_ACC);
		cmd.clr_wr = (state_q == S_CLR) || (state_q == S_INIT_CLR);
		cmd.corner = corner_q;
		busy       = (state_q != S_IDLE);
		done       = (state_q == S_DONE);
	end

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept without busy");
	a_acc_inside: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> $past(cmd.prod, 1) && $past(cmd.fact, 2)) else $error("corner seq");
	a_no_clr_corner: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !cmd.acc && !done) else $error("clear overlap");

endmodule

### hdl/cmdr_dp.sv
module cmdr_dp
	import cmdr_pkg::*;
#(
	parameter int REGION_X = REGION_X_DEF,
	parameter int REGION_Y = REGION_Y_DEF,
	parameter int REGION_Z = REGION_Z_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        cfg_valid,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  cmd_t        cmd,
	output sts_t        sts,
	output result_t     result
);

	localparam int DEPTH = REGION_X * REGION_Y * REGION_Z;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(REGION_X);
	localparam int YW    = $clog2(REGION_Y);
	localparam int ZW    = $clog2(REGION_Z);
	localparam logic signed [65:0] CMAX = 66'sh7FFF_FFFF_FFFF;
	localparam logic signed [65:0] CMIN = -66'sh8000_0000_0000;

	typedef struct packed {
		logic        ok;
		logic [15:0] c0;
		logic [15:0] c1;
	} wrap_t;

	typedef struct packed {
		logic        ins;
		logic [15:0] idx;
	} rel_t;

	function automatic wrap_t wrap_axis(input logic [31:0] g, input logic [15:0] mesh);
		wrap_t       r;
		logic [31:0] c0w;
		logic [16:0] c1w;
		r.ok = {1'b0, g} < {16'b0, mesh, 1'b0};
		c0w  = (g >= {16'b0, mesh}) ? g - {16'b0, mesh} : g;
		r.c0 = c0w[15:0];
		c1w  = {1'b0, r.c0} + 17'd1;
		if (c1w >= {1'b0, mesh})
			c1w = c1w - {1'b0, mesh};
		r.c1 = c1w[15:0];
		return r;
	endfunction

	function automatic rel_t rel_axis(input logic [15:0] c, input logic [15:0] st,
		input logic [16:0] region);
		rel_t        r;
		logic [16:0] d;
		d     = {1'b0, c} - {1'b0, st};
		r.ins = !d[16] && (d < region);
		r.idx = d[15:0];
		return r;
	endfunction

	function automatic logic [16:0] axis_w(input logic hi, input logic [15:0] frac);
		return hi ? {1'b0, frac} : 17'h10000 - {1'b0, frac};
	endfunction

	function automatic logic [48:0] clip48(input logic signed [65:0] v);
		if (v > CMAX)
			return {1'b1, CMAX[47:0]};
		if (v < CMIN)
			return {1'b1, CMIN[47:0]};
		return {1'b0, v[47:0]};
	endfunction

	logic [15:0] mesh_x_q, mesh_y_q, mesh_z_q, start_x_q, start_y_q;
	logic [31:0] inv_x_q, inv_y_q, inv_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_x_q  <= 16'd32;
			mesh_y_q  <= 16'd32;
			mesh_z_q  <= 16'd32;
			start_x_q <= '0;
			start_y_q <= '0;
			inv_x_q   <= 32'h0001_0000;
			inv_y_q   <= 32'h0001_0000;
			inv_z_q   <= 32'h0001_0000;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MESH_X:  mesh_x_q  <= cfg_data[15:0];
				CFG_MESH_Y:  mesh_y_q  <= cfg_data[15:0];
				CFG_MESH_Z:  mesh_z_q  <= cfg_data[15:0];
				CFG_START_X: start_x_q <= cfg_data[15:0];
				CFG_START_Y: start_y_q <= cfg_data[15:0];
				CFG_INV_X:   inv_x_q   <= cfg_data;
				CFG_INV_Y:   inv_y_q   <= cfg_data;
				CFG_INV_Z:   inv_z_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	item_t              item_q;
	logic [63:0]        prod_x_q, prod_y_q, prod_z_q;
	wrap_t              wx_q, wy_q, wz_q;
	logic               oor_q, sat_q;
	logic [1:0]         inx_q, iny_q, inz_q;
	logic [XW-1:0]      ix_q [2];
	logic [YW-1:0]      iy_q [2];
	logic [ZW-1:0]      iz_q [2];
	logic [33:0]        wxy_q;
	logic [32:0]        f_q;
	logic signed [64:0] dprod_q, ph_q, pl_q;
	logic signed [51:0] acc_q;
	logic [3:0]         touched_q;
	logic [AW-1:0]      clr_addr_q;
	logic [47:0]        rdata_q;
	logic [47:0]        mem [DEPTH];

	rel_t rx0, rx1, ry0, ry1, rz0, rz1;
	logic rxb, ryb, rzb;
	logic [16:0] wx, wy, wz;
	logic [AW-1:0] caddr, maddr;
	logic signed [47:0] rd_cell;
	logic signed [65:0] dsum;
	logic [81:0] rsum;
	logic signed [81:0] rterm;
	logic [48:0] dclip, aclip;
	logic mwe;
	logic [47:0] mwdata;

	assign rx0 = rel_axis(wx_q.c0, start_x_q, 17'(REGION_X));
	assign rx1 = rel_axis(wx_q.c1, start_x_q, 17'(REGION_X));
	assign ry0 = rel_axis(wy_q.c0, start_y_q, 17'(REGION_Y));
	assign ry1 = rel_axis(wy_q.c1, start_y_q, 17'(REGION_Y));
	assign rz0 = rel_axis(wz_q.c0, 16'd0, 17'(REGION_Z));
	assign rz1 = rel_axis(wz_q.c1, 16'd0, 17'(REGION_Z));

	assign rxb = cmd.corner[2];
	assign ryb = cmd.corner[1];
	assign rzb = cmd.corner[0];
	assign wx  = axis_w(rxb, prod_x_q[31:16]);
	assign wy  = axis_w(ryb, prod_y_q[31:16]);
	assign wz  = axis_w(rzb, prod_z_q[31:16]);

	assign caddr = AW'((AW'(iz_q[rzb]) * AW'(REGION_Y) + AW'(iy_q[ryb])) * AW'(REGION_X))
		+ AW'(ix_q[rxb]);
	assign rd_cell = $signed(rdata_q);
	assign dsum  = 66'(dprod_q >>> 24) + 66'(rd_cell);
	assign dclip = clip48(dsum);
	assign rsum  = 82'(ph_q) * 82'd65536 + 82'(pl_q);
	assign rterm = $signed(rsum) >>> 32;
	assign aclip = clip48(66'(acc_q));

	assign mwe    = cmd.clr_wr || (cmd.acc && item_q.mode == MODE_DEPOSIT);
	assign mwdata = cmd.clr_wr ? 48'd0 : dclip[47:0];
	assign maddr  = cmd.clr_wr ? clr_addr_q : caddr;

	always_ff @(posedge clk) begin
		if (mwe)
			mem[maddr] <= mwdata;
		else
			rdata_q <= mem[maddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			oor_q      <= 1'b0;
			sat_q      <= 1'b0;
			touched_q  <= '0;
			acc_q      <= '0;
			item_q     <= '0;
		end else begin
			if (cmd.load) begin
				item_q     <= item;
				clr_addr_q <= '0;
				oor_q      <= 1'b0;
				sat_q      <= 1'b0;
				touched_q  <= '0;
				acc_q      <= '0;
			end
			if (cmd.clr_wr)
				clr_addr_q <= clr_addr_q + AW'(1);
			if (cmd.wrap)
				oor_q <= !(wrap_axis(prod_x_q[63:32], mesh_x_q).ok
					&& wrap_axis(prod_y_q[63:32], mesh_y_q).ok
					&& wrap_axis(prod_z_q[63:32], mesh_z_q).ok);
			if (cmd.acc) begin
				touched_q <= touched_q + 4'd1;
				if (item_q.mode == MODE_DEPOSIT)
					sat_q <= sat_q | dclip[48];
				else
					acc_q <= acc_q + 52'(rterm);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_x_q <= 64'(item_q.pos_x) * 64'(inv_x_q);
			prod_y_q <= 64'(item_q.pos_y) * 64'(inv_y_q);
			prod_z_q <= 64'(item_q.pos_z) * 64'(inv_z_q);
		end
		if (cmd.wrap) begin
			wx_q <= wrap_axis(prod_x_q[63:32], mesh_x_q);
			wy_q <= wrap_axis(prod_y_q[63:32], mesh_y_q);
			wz_q <= wrap_axis(prod_z_q[63:32], mesh_z_q);
		end
		if (cmd.rel) begin
			inx_q   <= {rx1.ins, rx0.ins};
			iny_q   <= {ry1.ins, ry0.ins};
			inz_q   <= {rz1.ins, rz0.ins};
			ix_q[0] <= rx0.idx[XW-1:0];
			ix_q[1] <= rx1.idx[XW-1:0];
			iy_q[0] <= ry0.idx[YW-1:0];
			iy_q[1] <= ry1.idx[YW-1:0];
			iz_q[0] <= rz0.idx[ZW-1:0];
			iz_q[1] <= rz1.idx[ZW-1:0];
		end
		if (cmd.addr)
			wxy_q <= 34'(wx) * 34'(wy);
		if (cmd.fact)
			f_q <= 33'((50'(wxy_q) * 50'(wz)) >> 16);
		if (cmd.prod) begin
			dprod_q <= 65'(item_q.weight) * 65'($signed({1'b0, f_q}));
			ph_q    <= 65'(rd_cell) * 65'($signed({1'b0, f_q[32:16]}));
			pl_q    <= 65'(rd_cell) * 65'($signed({1'b0, f_q[15:0]}));
		end
	end

	assign sts.mode      = item_q.mode;
	assign sts.oor       = oor_q;
	assign sts.corner_in = inx_q[rxb] && iny_q[ryb] && inz_q[rzb];
	assign sts.clr_last  = (clr_addr_q == AW'(DEPTH - 1));

	always_comb begin
		result               = '0;
		result.cells_touched = touched_q;
		result.out_of_range  = oor_q;
		result.saturated     = sat_q;
		if (item_q.mode == MODE_READOUT && !oor_q) begin
			result.value     = $signed(aclip[47:0]);
			result.saturated = aclip[48];
		end
	end

endmodule

### hdl/cic_mesh_deposit_readout_unit.sv
// Deposit and readout: multiply, wrap and relative-index steps, then per corner
// an address step if outside the region, else address, factor, product and
// accumulate, via one single-port mesh memory; out of range skips the corners.
// Throughput: one item at a time, next item accepted the cycle after done.
// Reset: registers to defaults, then a clearing pass of one cell per cycle over
// the whole store with busy high; the receiver cannot stall results.
module cic_mesh_deposit_readout_unit
	import cmdr_pkg::*;
#(
	parameter int REGION_X = REGION_X_DEF,
	parameter int REGION_Y = REGION_Y_DEF,
	parameter int REGION_Z = REGION_Z_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	cmdr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cmdr_dp #(
		.REGION_X (REGION_X),
		.REGION_Y (REGION_Y),
		.REGION_Z (REGION_Z)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

endmodule

### sim/cic_mesh_deposit_readout_unit_test.sv
`timescale 1ns / 1ps

module cic_mesh_deposit_readout_unit_test;
	import cmdr_pkg::*;

	localparam int NX = REGION_X_DEF;
	localparam int NY = REGION_Y_DEF;
	localparam int NZ = REGION_Z_DEF;
	localparam longint CELL_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint CELL_MIN = -64'sh8000_0000_0000;
	localparam longint LIMIT = 4000000;
	localparam int SETTLE = 40;
	localparam logic [3:0] CFG_UNUSED = 4'd9;

	class mesh_model;
		longint cells [NX*NY*NZ];
		logic [15:0] mesh [3];
		logic [15:0] org [2];
		logic [31:0] inv [3];
		result_t pending_results [$];
		int mismatches;

		function new();
			foreach (cells[i]) cells[i] = 0;
			foreach (mesh[i]) mesh[i] = 16'd32;
			foreach (inv[i]) inv[i] = 32'd65536;
			org[0] = 0;
			org[1] = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [3:0] idx, logic [31:0] data);
			case (idx)
				CFG_MESH_X:  mesh[0] = data[15:0];
				CFG_MESH_Y:  mesh[1] = data[15:0];
				CFG_MESH_Z:  mesh[2] = data[15:0];
				CFG_START_X: org[0] = data[15:0];
				CFG_START_Y: org[1] = data[15:0];
				CFG_INV_X:   inv[0] = data;
				CFG_INV_Y:   inv[1] = data;
				CFG_INV_Z:   inv[2] = data;
				default: ;
			endcase
		endfunction

		function void map_axis(logic [31:0] pos, logic [31:0] iv, logic [15:0] m,
				logic [15:0] o, output bit ok, output longint lo, output longint hi,
				output longint frac);
			logic [63:0] prod, g, c0, c1, m64;
			m64 = {48'd0, m};
			prod = {32'd0, pos} * {32'd0, iv};
			g = prod >> 32;
			frac = longint'({48'd0, prod[31:16]});
			ok = g < (m64 << 1);
			c0 = (g >= m64) ? g - m64 : g;
			c1 = c0 + 1;
			if (c1 >= m64)
				c1 = c1 - m64;
			lo = longint'({32'd0, c0[31:0]}) - longint'({48'd0, o});
			hi = longint'({32'd0, c1[31:0]}) - longint'({48'd0, o});
		endfunction

		function longint clip(longint v, inout bit sat);
			if (v > CELL_MAX) begin
				sat = 1;
				return CELL_MAX;
			end
			if (v < CELL_MIN) begin
				sat = 1;
				return CELL_MIN;
			end
			return v;
		endfunction

		function void note_item(item_t it);
			result_t r;
			bit okx, oky, okz, sat;
			longint cx [2], cy [2], cz [2], wx [2], wy [2], wz [2];
			longint fx, fy, fz, f, acc, wt, add;
			logic signed [127:0] p;
			int idx, touched;
			r = '0;
			sat = 0;
			acc = 0;
			touched = 0;
			wt = longint'(it.weight);
			if (it.mode == MODE_CLEAR) begin
				foreach (cells[i]) cells[i] = 0;
			end else if (it.mode != MODE_NONE) begin
				map_axis(it.pos_x, inv[0], mesh[0], org[0], okx, cx[0], cx[1], fx);
				map_axis(it.pos_y, inv[1], mesh[1], org[1], oky, cy[0], cy[1], fy);
				map_axis(it.pos_z, inv[2], mesh[2], 16'd0, okz, cz[0], cz[1], fz);
				wx[0] = 65536 - fx; wx[1] = fx;
				wy[0] = 65536 - fy; wy[1] = fy;
				wz[0] = 65536 - fz; wz[1] = fz;
				if (!(okx && oky && okz)) begin
					r.out_of_range = 1'b1;
				end else begin
					for (int n = 0; n < 8; n++) begin
						int a, b, c;
						a = (n >> 2) & 1;
						b = (n >> 1) & 1;
						c = n & 1;
						if (cx[a] < 0 || cx[a] >= NX || cy[b] < 0 || cy[b] >= NY ||
								cz[c] < 0 || cz[c] >= NZ)
							continue;
						idx = int'((cz[c] * NY + cy[b]) * NX + cx[a]);
						f = (wx[a] * wy[b] * wz[c]) >>> 16;
						touched++;
						if (it.mode == MODE_DEPOSIT) begin
							add = (wt * f) >>> 24;
							cells[idx] = clip(cells[idx] + add, sat);
						end else begin
							p = cells[idx];
							p = p * f;
							acc += longint'(p >>> 32);
						end
					end
					if (it.mode == MODE_READOUT)
						r.value = 48'(clip(acc, sat));
					r.cells_touched = touched[3:0];
					r.saturated = sat;
				end
			end
			pending_results.push_back(r);
		endfunction

		task report(string msg);
			$display("tb: mismatch %s", msg);
			mismatches++;
		endtask

		task check_result(result_t got);
			result_t exp;
			if (pending_results.size() == 0) begin
				report("result with nothing expected");
				return;
			end
			exp = pending_results.pop_front();
			if (got.value !== exp.value)
				report($sformatf("value %h exp %h", got.value, exp.value));
			if (got.cells_touched !== exp.cells_touched)
				report($sformatf("cells_touched %0d exp %0d", got.cells_touched,
					exp.cells_touched));
			if (got.out_of_range !== exp.out_of_range)
				report($sformatf("out_of_range %b exp %b", got.out_of_range,
					exp.out_of_range));
			if (got.saturated !== exp.saturated)
				report($sformatf("saturated %b exp %b", got.saturated, exp.saturated));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	item_t item = '0;
	logic done;
	result_t result;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [3:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	longint cycles = 0;
	mesh_model model = new();
	bit no_gaps = 0;
	bit heavy_sign = 0;
	logic [31:0] hot [3];

	cic_mesh_deposit_readout_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			model.check_result(result);
	end

	task send_item(item_t it);
		int gap;
		if ($urandom_range(0, 19) == 0)
			no_gaps = ~no_gaps;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		model.note_item(it);
	endtask

	task drain();
		start <= 1'b0;
		do @(posedge clk); while (model.pending_results.size() != 0 || busy);
		repeat (SETTLE) @(posedge clk);
	endtask

	task write_reg(logic [3:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model.write_reg(idx, data);
	endtask

	function logic [31:0] pick_pos(int ax);
		longint lim;
		if ($urandom_range(0, 9) < 2)
			return $urandom;
		lim = ((longint'({48'd0, model.mesh[ax]}) << 33) - 1) / longint'({32'd0, model.inv[ax]});
		if (lim > 64'hFFFF_FFFF)
			lim = 64'hFFFF_FFFF;
		return $urandom_range(0, lim[31:0]);
	endfunction

	function item_t mk(logic [1:0] m, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] w);
		item_t it;
		it.mode = m;
		it.pos_x = x;
		it.pos_y = y;
		it.pos_z = z;
		it.weight = w;
		return it;
	endfunction

	task config_phase(int ph);
		logic [15:0] m [3];
		logic [15:0] o [2];
		logic [31:0] iv [3];
		for (int a = 0; a < 3; a++) begin
			m[a] = 16'($urandom_range(16, 48));
			iv[a] = ($urandom_range(0, 2) == 0) ? $urandom_range(20000, 140000) : 32'd65536;
		end
		o[0] = 16'($urandom_range(0, 12));
		o[1] = 16'($urandom_range(0, 12));
		case (ph)
			1: begin
				m = '{16'd1, 16'd1, 16'd1};
				o = '{16'd0, 16'd0};
			end
			2: begin
				m = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
				o = '{16'hFFFF, 16'hFFE8};
				iv = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1};
			end
			3: begin
				m = '{16'd2, 16'd3, 16'd0};
				iv[2] = 32'd65536;
			end
			4: begin
				m = '{16'd3, 16'd2, 16'd2};
				iv = '{32'd1, 32'd65536, 32'd32768};
				o = '{16'd1, 16'd0};
			end
			default: ;
		endcase
		write_reg(CFG_MESH_X, {16'($urandom_range(0, 65535)), m[0]});
		write_reg(CFG_MESH_Y, {16'd0, m[1]});
		write_reg(CFG_MESH_Z, {16'd0, m[2]});
		write_reg(CFG_START_X, {16'($urandom_range(0, 65535)), o[0]});
		write_reg(CFG_START_Y, {16'd0, o[1]});
		write_reg(CFG_INV_X, iv[0]);
		write_reg(CFG_INV_Y, iv[1]);
		write_reg(CFG_INV_Z, iv[2]);
		write_reg(CFG_UNUSED, $urandom);
	endtask

	task random_items(int count, int hot_pct);
		int r;
		logic [1:0] m;
		logic [31:0] w;
		for (int a = 0; a < 3; a++) hot[a] = pick_pos(a);
		heavy_sign = $urandom_range(0, 1);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < hot_pct) begin
				w = heavy_sign ? 32'h8000_0000 | $urandom_range(0, 65535)
					: 32'h7FFF_0000 | $urandom_range(0, 65535);
				m = ($urandom_range(0, 7) == 0) ? MODE_READOUT : MODE_DEPOSIT;
				send_item(mk(m, hot[0], hot[1], hot[2], w));
			end else begin
				r = $urandom_range(0, 199);
				if (r == 0)
					m = MODE_CLEAR;
				else if (r < 6)
					m = MODE_NONE;
				else if (r < 100)
					m = MODE_DEPOSIT;
				else
					m = MODE_READOUT;
				send_item(mk(m, pick_pos(0), pick_pos(1), pick_pos(2), $urandom));
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (busy);

		send_item(mk(MODE_READOUT, 32'd0, 32'd0, 32'd0, 32'd0));
		send_item(mk(MODE_DEPOSIT, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF));
		send_item(mk(MODE_READOUT, 32'd0, 32'd0, 32'd0, 32'd0));
		send_item(mk(MODE_DEPOSIT, 32'h0001_8000, 32'h0002_4000, 32'h0003_C000,
			32'h8000_0000));
		send_item(mk(MODE_READOUT, 32'h0001_8000, 32'h0002_4000, 32'h0003_C000, 32'd0));
		send_item(mk(MODE_DEPOSIT, 32'h001F_FFFF, 32'h001F_8000, 32'h001F_0001,
			32'h0001_0000));
		send_item(mk(MODE_READOUT, 32'h001F_FFFF, 32'h001F_8000, 32'h001F_0001, 32'd0));
		send_item(mk(MODE_DEPOSIT, 32'h0025_0000, 32'h003F_FFFF, 32'h0020_0000,
			32'hFFFF_FFFF));
		send_item(mk(MODE_READOUT, 32'h0025_0000, 32'h003F_FFFF, 32'h0020_0000, 32'd0));
		send_item(mk(MODE_DEPOSIT, 32'h0040_0000, 32'd0, 32'd0, 32'h0001_0000));
		send_item(mk(MODE_READOUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
		send_item(mk(MODE_NONE, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF));
		send_item(mk(MODE_READOUT, 32'd0, 32'd0, 32'd0, 32'd0));
		send_item(mk(MODE_CLEAR, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF));
		send_item(mk(MODE_READOUT, 32'h0001_8000, 32'h0002_4000, 32'h0003_C000, 32'd0));
		drain();

		config_phase(1);
		send_item(mk(MODE_DEPOSIT, 32'h0001_8000, 32'h0000_4000, 32'd0, 32'h7FFF_FFFF));
		send_item(mk(MODE_READOUT, 32'h0000_8000, 32'h0001_4000, 32'd0, 32'd0));
		random_items(330, 85);
		drain();
		write_reg(CFG_MESH_X, 32'd0);
		send_item(mk(MODE_DEPOSIT, 32'd0, 32'd0, 32'd0, 32'h0001_0000));
		drain();

		for (int ph = 2; ph < 9; ph++) begin
			config_phase(ph);
			random_items(160, 8);
			drain();
		end

		if (model.mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### cic_mesh_deposit_readout_unit.f
hdl/cmdr_pkg.sv
hdl/cmdr_ctrl.sv
hdl/cmdr_dp.sv
hdl/cic_mesh_deposit_readout_unit.sv
sim/cic_mesh_deposit_readout_unit_test.sv
